// ===== src/csd_pkg.sv =====
// Shared types and constants for the charge stall detector.
// Used by csd_cfg_regs, csd_eval and charge_stall_detector; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csd_pkg;

  localparam int unsigned PctW  = 7;
  localparam int unsigned TimeW = 32;
  localparam int unsigned WinW  = 27;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = WinW;

  localparam logic [ByteW-1:0] CHARGING_MASK = 8'h30;
  localparam logic [ByteW-1:0] MODE_RETURN   = 8'd4;
  localparam logic [ByteW-1:0] MODE_DOCKING  = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PCT_LOW  = 2'd0,
    CFG_PCT_HIGH = 2'd1,
    CFG_RISE     = 2'd2,
    CFG_WINDOW   = 2'd3
  } cfg_reg_e;

  localparam logic [PctW-1:0] PCT_LOW_RST  = 7'd1;
  localparam logic [PctW-1:0] PCT_HIGH_RST = 7'd60;
  localparam logic [PctW-1:0] RISE_RST     = 7'd2;
  localparam logic [WinW-1:0] WINDOW_RST   = 27'd1200000;

  typedef struct packed {
    logic [PctW-1:0] pct_low;
    logic [PctW-1:0] pct_high;
    logic [PctW-1:0] rise_limit;
    logic [WinW-1:0] window_ms;
  } cfg_t;

  typedef struct packed {
    logic              data_fresh;
    logic [TimeW-1:0]  time_ms;
    logic [PctW-1:0]   charge_pct;
    logic [ByteW-1:0]  dock_status;
    logic [ByteW-1:0]  robot_mode;
  } tick_t;

  typedef struct packed {
    logic [TimeW-1:0] window_start;
    logic [PctW-1:0]  start_percent;
    logic             error_flag;
    logic             window_idle;
  } det_state_t;

endpackage
`default_nettype wire

// ===== src/csd_cfg_regs.sv =====
// Configuration register file for the charge stall detector.
// Depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csd_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [csd_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [csd_pkg::CfgDataW-1:0]  wr_data,
  output csd_pkg::cfg_t                      cfg
);
  import csd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        CFG_PCT_LOW:  cfg_nxt.pct_low    = wr_data[PctW-1:0];
        CFG_PCT_HIGH: cfg_nxt.pct_high   = wr_data[PctW-1:0];
        CFG_RISE:     cfg_nxt.rise_limit = wr_data[PctW-1:0];
        CFG_WINDOW:   cfg_nxt.window_ms  = wr_data[WinW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pct_low    <= PCT_LOW_RST;
      cfg_r.pct_high   <= PCT_HIGH_RST;
      cfg_r.rise_limit <= RISE_RST;
      cfg_r.window_ms  <= WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/csd_eval.sv =====
// Per-tick decision logic: next detector state and reported error flag.
// Purely combinational; depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csd_eval (
  input  csd_pkg::cfg_t       cfg,
  input  csd_pkg::tick_t      tick,
  input  csd_pkg::det_state_t cur,
  output csd_pkg::det_state_t nxt,
  output logic                err
);
  import csd_pkg::*;

  logic             charging;
  logic             clear_mode;
  logic             in_band;
  logic [TimeW-1:0] start_eff;
  logic [PctW-1:0]  start_pct_eff;
  logic [TimeW-1:0] elapsed;
  logic             expired;
  logic signed [PctW:0] rise;
  logic             stalled;

  assign charging   = (tick.dock_status & CHARGING_MASK) != '0;
  assign clear_mode = (tick.robot_mode == MODE_RETURN) || (tick.robot_mode == MODE_DOCKING);
  assign in_band    = (cfg.pct_low <= tick.charge_pct) &&
                      (tick.charge_pct <= cfg.pct_high);

  // An idle window opens at this tick.
  assign start_eff     = cur.window_idle ? tick.time_ms : cur.window_start;
  assign start_pct_eff = cur.window_idle ? tick.charge_pct : cur.start_percent;
  assign elapsed       = tick.time_ms - start_eff;
  assign expired       = elapsed >= {{(TimeW-WinW){1'b0}}, cfg.window_ms};
  assign rise          = $signed({1'b0, tick.charge_pct}) - $signed({1'b0, start_pct_eff});
  assign stalled       = rise <= $signed({1'b0, cfg.rise_limit});

  always_comb begin
    nxt = cur;
    priority if (clear_mode) begin
      nxt.window_start  = tick.time_ms;
      nxt.start_percent = tick.charge_pct;
      nxt.error_flag    = 1'b0;
      nxt.window_idle   = 1'b1;
    end else if (!cur.error_flag && charging) begin
      if (in_band) begin
        nxt.window_start  = start_eff;
        nxt.start_percent = start_pct_eff;
        nxt.window_idle   = 1'b0;
        if (expired) begin
          nxt.error_flag  = stalled;
          nxt.window_idle = 1'b1;
        end
      end else begin
        nxt.error_flag  = 1'b0;
        nxt.window_idle = 1'b1;
      end
    end else begin
      nxt.window_start  = tick.time_ms;
      nxt.start_percent = tick.charge_pct;
      nxt.window_idle   = 1'b1;
    end
  end

  assign err = nxt.error_flag;

endmodule
`default_nettype wire

// ===== src/charge_stall_detector.sv =====
// Charge stall detector top level: input register, decision logic, result register.
// Tick and result each registered; 1 tick per cycle while out_ready does not stall.
// Stale ticks (data_fresh low) pass the input register and are dropped, giving no result.
// Reset (rst_n low, synchronous) empties both registers, closes the window, clears
// the error and loads the configuration defaults.
// Depends on csd_pkg, csd_cfg_regs and csd_eval.
`timescale 1ns / 1ps
`default_nettype none
module charge_stall_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // tick input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_data_fresh,
  input  wire logic [csd_pkg::TimeW-1:0]     in_time_ms,
  input  wire logic [csd_pkg::PctW-1:0]      in_charge_pct,
  input  wire logic [csd_pkg::ByteW-1:0]     in_dock_status,
  input  wire logic [csd_pkg::ByteW-1:0]     in_robot_mode,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_charge_error,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [csd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [csd_pkg::CfgDataW-1:0]  cfg_data
);
  import csd_pkg::*;

  cfg_t       cfg;
  tick_t      tick_r;
  logic       tick_valid_r, tick_valid_nxt;
  det_state_t state_r, state_nxt;
  det_state_t eval_state;
  logic       eval_err;
  logic       out_valid_r, out_valid_nxt;
  logic       out_err_r;
  logic       advance;
  logic       emit;
  logic       in_fire;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  csd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  csd_eval u_eval (
    .cfg  (cfg),
    .tick (tick_r),
    .cur  (state_r),
    .nxt  (eval_state),
    .err  (eval_err)
  );

  // The held tick moves on when the result register is free or being drained.
  // A stale tick needs no result slot, so it always moves on.
  assign emit     = tick_valid_r && tick_r.data_fresh;
  assign advance  = tick_valid_r && (!tick_r.data_fresh || !out_valid_r || out_ready);
  assign in_ready = !tick_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    tick_valid_nxt = tick_valid_r;
    if (in_fire) begin
      tick_valid_nxt = 1'b1;
    end else if (advance) begin
      tick_valid_nxt = 1'b0;
    end
  end

  // Advance detector state only for fresh ticks; stale ticks change nothing.
  always_comb begin
    state_nxt = state_r;
    if (advance && emit) begin
      state_nxt = eval_state;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r          <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.window_start  <= '0;
      state_r.start_percent <= '0;
      state_r.error_flag    <= 1'b0;
      state_r.window_idle   <= 1'b1;
    end else begin
      tick_valid_r <= tick_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      state_r      <= state_nxt;
    end
  end

  // Payload registers: capture on transaction, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_r.data_fresh  <= in_data_fresh;
      tick_r.time_ms     <= in_time_ms;
      tick_r.charge_pct  <= in_charge_pct;
      tick_r.dock_status <= in_dock_status;
      tick_r.robot_mode  <= in_robot_mode;
    end
    if (advance && emit) begin
      out_err_r <= eval_err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_charge_error = out_err_r;

endmodule
`default_nettype wire
